@@ rtl/qa3_pkg.sv @@
// ----------------------------------------------------------------------------
// qa3_pkg
// Shared widths and types for the quad area block.
// ----------------------------------------------------------------------------
package qa3_pkg;

    localparam int FIELD_WIDTH  = 24;   // width of one coordinate field on the bus
    localparam int NUM_COORDS   = 12;   // four vertices, three axes each
    localparam int AREA_WIDTH   = 52;
    localparam int S_TDATA_WIDTH = ((NUM_COORDS * FIELD_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((AREA_WIDTH + 7) / 8) * 8;

    typedef logic [AREA_WIDTH-1:0] area_t;

endpackage

@@ rtl/quad_area_3d.sv @@
// ----------------------------------------------------------------------------
// quad_area_3d
// Quad area as half the summed cross product lengths of triangles ABC, ACD.
// ----------------------------------------------------------------------------
//  channel  | ports                 | payload
//  ---------+-----------------------+-----------------------------------------
//  input    | s_tvalid/s_tready     | s_tdata: 12 coords, 24b each
//  result   | m_tvalid/m_tready     | m_tdata: area (52b), m_tuser: degenerate
//  config   | cfg_wr_en             | cfg_wr_data: area threshold (52b)
//
// One transaction per cycle unless m_tready stalls; the depth is the square root
// pipeline (one root bit per stage) plus 8 arithmetic stages.
// aresetn clears all valid bits and the threshold.
// A stall on m_tready freezes the whole pipeline; s_tready = !m_tvalid | m_tready.
// ----------------------------------------------------------------------------
module quad_area_3d import qa3_pkg::*; #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // a_x, a_y, a_z, b_x, ..., d_z (24b each, lowest first)
    input  logic [S_TDATA_WIDTH-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // quad_area_value (52b), zero pad
    output logic [M_TDATA_WIDTH-1:0]  m_tdata,
    // degenerate
    output logic                      m_tuser,
    input  logic                      cfg_wr_en,
    input  logic [AREA_WIDTH-1:0]     cfg_wr_data
);

    localparam int W = COORD_WIDTH;
    localparam int D = W + 1;
    localparam int M = 2 * D;
    localparam int R = M + 1;
    localparam int S = 2 * R;

    logic                    en;
    logic [NUM_COORDS*W-1:0] crd_flat;
    logic                    cx_valid, sq_valid, rt0_valid, rt1_valid;
    logic [M-1:0]            mag [6];
    logic [S-1:0]            sum [2];
    logic [R-1:0]            root0, root1;
    logic [R:0]              root_sum;
    logic [R-1:0]            area_reg;
    logic                    area_valid_reg;
    area_t                   thr_reg;
    area_t                   out_area_reg;
    logic                    out_degen_reg;
    logic                    out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            crd_flat[k*W +: W] = s_tdata[k*FIELD_WIDTH +: W];
        end
    end

    qa3_cross #(.W(W)) u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .crd_flat  (crd_flat),
        .out_valid (cx_valid),
        .mag       (mag)
    );

    qa3_sqsum #(.D(D)) u_sqsum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cx_valid),
        .mag       (mag),
        .out_valid (sq_valid),
        .sum       (sum)
    );

    qa3_isqrt #(.R(R)) u_isqrt0 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .rad       (sum[0]),
        .out_valid (rt0_valid),
        .root      (root0)
    );

    qa3_isqrt #(.R(R)) u_isqrt1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .rad       (sum[1]),
        .out_valid (rt1_valid),
        .root      (root1)
    );

    assign root_sum = (R+1)'(root0) + (R+1)'(root1);

    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg      <= root_sum[R:1];
            out_area_reg  <= AREA_WIDTH'(area_reg);
            out_degen_reg <= AREA_WIDTH'(area_reg) <= thr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= '0;
        end else begin
            if (en) begin
                area_valid_reg <= rt0_valid;
                out_valid_reg  <= area_valid_reg;
            end
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(out_area_reg);
    assign m_tuser  = out_degen_reg;

`ifndef SYNTHESIS
    a_roots_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        rt0_valid == rt1_valid)
        else $error("square root pipelines out of step");

    a_zero_degenerate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_area_reg == '0 |-> m_tuser)
        else $error("zero area not flagged degenerate");

    a_stall_only_when_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_reset_clears: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

@@ rtl/qa3_cross.sv @@
// ----------------------------------------------------------------------------
// qa3_cross
// Edge vectors, cross products and component magnitudes for both triangles.
// ----------------------------------------------------------------------------
module qa3_cross import qa3_pkg::*; #(
    parameter int W = 24,
    localparam int D = W + 1,
    localparam int M = 2 * D
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [NUM_COORDS*W-1:0]   crd_flat,
    output logic                      out_valid,
    output logic [M-1:0]              mag [6]
);

    logic signed [W-1:0]   crd [NUM_COORDS];
    logic signed [D-1:0]   dif_next [9];
    logic signed [D-1:0]   dif_reg  [9];
    logic signed [2*D-1:0] prod_next [12];
    logic signed [2*D-1:0] prod_reg  [12];
    logic signed [2*D:0]   crs [6];
    logic [M-1:0]          mag_next [6];
    logic [M-1:0]          mag_reg  [6];
    logic                  v1_reg, v2_reg, v3_reg;

    // stage 1: u = B-A, v = C-A, w = D-A
    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            crd[k] = $signed(crd_flat[k*W +: W]);
        end
        for (int i = 0; i < 3; i++) begin
            dif_next[i]     = D'(crd[3+i]) - D'(crd[i]);
            dif_next[3+i]   = D'(crd[6+i]) - D'(crd[i]);
            dif_next[6+i]   = D'(crd[9+i]) - D'(crd[i]);
        end
    end

    // stage 2: cross product terms, triangle 0 uses (u,v), triangle 1 (v,w)
    always_comb begin
        for (int t = 0; t < 2; t++) begin
            prod_next[6*t+0] = dif_reg[3*t+1] * dif_reg[3*t+5];
            prod_next[6*t+1] = dif_reg[3*t+2] * dif_reg[3*t+4];
            prod_next[6*t+2] = dif_reg[3*t+2] * dif_reg[3*t+3];
            prod_next[6*t+3] = dif_reg[3*t+0] * dif_reg[3*t+5];
            prod_next[6*t+4] = dif_reg[3*t+0] * dif_reg[3*t+4];
            prod_next[6*t+5] = dif_reg[3*t+1] * dif_reg[3*t+3];
        end
    end

    // stage 3: components and their magnitudes
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            crs[k]      = (2*D+1)'(prod_reg[2*k]) - (2*D+1)'(prod_reg[2*k+1]);
            mag_next[k] = crs[k][2*D] ? M'(-crs[k]) : M'(crs[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dif_reg  <= dif_next;
            prod_reg <= prod_next;
            mag_reg  <= mag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign mag       = mag_reg;

endmodule

@@ rtl/qa3_sqsum.sv @@
// ----------------------------------------------------------------------------
// qa3_sqsum
// Squared length of each cross product, from half-width partial products.
// ----------------------------------------------------------------------------
module qa3_sqsum #(
    parameter int D = 25,
    localparam int M = 2 * D,
    localparam int Q = 4 * D,
    localparam int S = 4 * D + 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [M-1:0]  mag [6],
    output logic          out_valid,
    output logic [S-1:0]  sum [2]
);

    logic [2*D-1:0] hh_next [6], hl_next [6], ll_next [6];
    logic [2*D-1:0] hh_reg  [6], hl_reg  [6], ll_reg  [6];
    logic [Q-1:0]   sq_next [6];
    logic [Q-1:0]   sq_reg  [6];
    logic [S-1:0]   sum_next [2];
    logic [S-1:0]   sum_reg  [2];
    logic           va_reg, vb_reg, vc_reg;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            hh_next[i] = mag[i][M-1:D] * mag[i][M-1:D];
            hl_next[i] = mag[i][M-1:D] * mag[i][D-1:0];
            ll_next[i] = mag[i][D-1:0] * mag[i][D-1:0];
            // (h*2^D + l)^2 = h^2*2^2D + 2hl*2^D + l^2
            sq_next[i] = (Q'(hh_reg[i]) << (2*D)) + (Q'(hl_reg[i]) << (D+1))
                       + Q'(ll_reg[i]);
        end
        for (int t = 0; t < 2; t++) begin
            sum_next[t] = S'(sq_reg[3*t]) + S'(sq_reg[3*t+1]) + S'(sq_reg[3*t+2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hh_reg  <= hh_next;
            hl_reg  <= hl_next;
            ll_reg  <= ll_next;
            sq_reg  <= sq_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign sum       = sum_reg;

endmodule

@@ rtl/qa3_isqrt.sv @@
// ----------------------------------------------------------------------------
// qa3_isqrt
// Pipelined floor square root, one root bit per stage (restoring method).
// ----------------------------------------------------------------------------
module qa3_isqrt #(
    parameter int R = 51,
    localparam int S = 2 * R
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [S-1:0]  rad,
    output logic          out_valid,
    output logic [R-1:0]  root
);

    logic [S-1:0]   rad_reg  [R];
    logic [R+1:0]   rem_reg  [R];
    logic [R-1:0]   root_reg [R];
    logic           vld_reg  [R];

    for (genvar k = 0; k < R; k++) begin : g_stage
        logic [S-1:0] rad_in;
        logic [R+1:0] rem_in;
        logic [R-1:0] root_in;
        logic         vld_in;
        logic [R+3:0] cur;
        logic [R+4:0] diff;
        logic         ok;

        if (k == 0) begin : g_first
            assign rad_in  = rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign vld_in  = in_valid;
        end else begin : g_rest
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb begin
            cur  = {rem_in, rad_in[S-1:S-2]};
            diff = {1'b0, cur} - (R+5)'({root_in, 2'b01});
            ok   = !diff[R+4];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= ok ? diff[R+1:0] : cur[R+1:0];
                root_reg[k] <= {root_in[R-2:0], ok};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    assign out_valid = vld_reg[R-1];
    assign root      = root_reg[R-1];

endmodule

@@ bench/quad_area_checker.sv @@
// ----------------------------------------------------------------------------
// quad_area_checker
// Watches the quad and area streams, predicts each area and degenerate flag
// from the accepted vertices and the current threshold, and compares in order.
// ----------------------------------------------------------------------------
module quad_area_checker import qa3_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [S_TDATA_WIDTH-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [M_TDATA_WIDTH-1:0]  m_tdata,
    input  logic                      m_tuser,
    input  logic                      cfg_wr_en,
    input  logic [AREA_WIDTH-1:0]     cfg_wr_data,
    output int                        fail_count,
    output int                        pending_areas
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        area_t area;
        logic  degenerate;
    } quad_result_t;

    area_t        threshold;
    quad_result_t area_queue[$];

    function automatic logic [50:0] isqrt_floor(logic [127:0] n);
        logic [50:0]  root;
        logic [50:0]  cand;
        logic [127:0] sq;
        root = '0;
        for (int b = 50; b >= 0; b--) begin
            cand = root | (51'd1 << b);
            sq = 128'(cand) * 128'(cand);
            if (sq <= n) root = cand;
        end
        return root;
    endfunction

    // Twice the triangle area: floor of the cross product length.
    function automatic logic [50:0] twice_tri_area(
        longint px, longint py, longint pz, longint qx, longint qy, longint qz,
        longint rx, longint ry, longint rz);
        longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
        logic [127:0] len_sq;
        ux = qx - px; uy = qy - py; uz = qz - pz;
        vx = rx - px; vy = ry - py; vz = rz - pz;
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        if (cx < 0) cx = -cx;
        if (cy < 0) cy = -cy;
        if (cz < 0) cz = -cz;
        len_sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
        return isqrt_floor(len_sq);
    endfunction

    function automatic quad_result_t quad_area_of(logic [S_TDATA_WIDTH-1:0] d, area_t thr);
        longint c[12];
        logic [52:0] sum;
        quad_result_t r;
        for (int i = 0; i < 12; i++) c[i] = longint'($signed(d[i*FIELD_WIDTH +: FIELD_WIDTH]));
        sum = 53'(twice_tri_area(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]))
            + 53'(twice_tri_area(c[0], c[1], c[2], c[6], c[7], c[8], c[9], c[10], c[11]));
        r.area = sum[52:1];
        r.degenerate = (r.area <= thr);
        return r;
    endfunction

    assign pending_areas = area_queue.size();

    always @(posedge aclk) begin
        quad_result_t exp_r;
        int errs;
        errs = 0;
        if (!aresetn) begin
            threshold <= '0;
            fail_count <= 0;
            area_queue.delete();
        end else begin
            if (cfg_wr_en) threshold <= cfg_wr_data;
            if (s_tvalid && s_tready) area_queue.push_back(quad_area_of(s_tdata, threshold));
            if (m_tvalid && m_tready) begin
                if (area_queue.size() == 0) begin
                    $error("area transaction with nothing expected");
                    errs++;
                end else begin
                    exp_r = area_queue.pop_front();
                    if (m_tdata[AREA_WIDTH-1:0] !== exp_r.area) begin
                        $error("quad_area_value: expected %0d, got %0d", exp_r.area,
                               m_tdata[AREA_WIDTH-1:0]);
                        errs++;
                    end
                    if (m_tuser !== exp_r.degenerate) begin
                        $error("degenerate: expected %0b, got %0b", exp_r.degenerate, m_tuser);
                        errs++;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end
endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives quads into quad_area_3d under several idle/stall mixes and threshold
// settings; the checker predicts and compares every area transaction.
// ----------------------------------------------------------------------------
module testbench;
    import qa3_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 2 * 24 + 11;
    localparam int MAXC = 8388607;
    localparam int MINC = -8388608;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [S_TDATA_WIDTH-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [M_TDATA_WIDTH-1:0]  m_tdata;
    logic                      m_tuser;
    logic                      cfg_wr_en;
    logic [AREA_WIDTH-1:0]     cfg_wr_data;
    int                        fail_count;
    int                        pending_areas;
    int                        send_idle_pct;
    int                        stall_pct;

    quad_area_3d #(.COORD_WIDTH(24)) u_dut (.*);
    quad_area_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver stall, redrawn each falling edge
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    function automatic logic [23:0] rand_coord(int mode);
        case (mode)
            0: return 24'($urandom_range(255));
            1: return 24'(MAXC - int'($urandom_range(255)));
            2: return 24'(MINC + int'($urandom_range(255)));
            default: return 24'($urandom);
        endcase
    endfunction

    // leaves s_tvalid high at the falling edge after acceptance; the next call
    // or drain() decides whether it drops
    task automatic send_quad(logic [S_TDATA_WIDTH-1:0] quad);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= quad;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_areas != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_threshold(area_t thr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [S_TDATA_WIDTH-1:0] quad_of(int c[12]);
        logic [S_TDATA_WIDTH-1:0] d;
        d = '0;
        for (int i = 0; i < 12; i++) d[i*24 +: 24] = 24'(c[i]);
        return d;
    endfunction

    task automatic random_phase(int count);
        logic [S_TDATA_WIDTH-1:0] d;
        int mode;
        int base[3];
        for (int n = 0; n < count; n++) begin
            d = '0;
            mode = $urandom_range(5);
            if (mode == 4) begin
                // near-degenerate: small offsets around a shared random point
                for (int k = 0; k < 3; k++) base[k] = $urandom_range(4000000);
                for (int i = 0; i < 12; i++)
                    d[i*24 +: 24] = 24'(base[i % 3] + int'($urandom_range(7)));
            end else begin
                for (int i = 0; i < 12; i++)
                    d[i*24 +: 24] = rand_coord(mode == 5 ? $urandom_range(3) : mode);
            end
            send_quad(d);
        end
    endtask

    initial begin
        int c[12];
        area_t thr[4];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: zero, coincident, collinear, 4096 square, extremes, unit square
        c = '{default: 0};
        send_quad(quad_of(c));
        c = '{5, 6, 7, 5, 6, 7, 5, 6, 7, 5, 6, 7};
        send_quad(quad_of(c));
        c = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3};
        send_quad(quad_of(c));
        c = '{0, 0, 0, 4096, 0, 0, 4096, 4096, 0, 0, 4096, 0};
        send_quad(quad_of(c));
        c = '{MINC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MINC};
        send_quad(quad_of(c));
        c = '{MINC, MINC, MINC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MAXC};
        send_quad(quad_of(c));
        c = '{MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC, MINC, MINC, MINC};
        send_quad(quad_of(c));
        c = '{-1, -1, -1, MAXC, 0, MINC, 0, MINC, MAXC, MINC, MAXC, 0};
        send_quad(quad_of(c));
        c = '{1, 2, 3, 2, 2, 3, 2, 3, 3, 1, 3, 3};
        send_quad(quad_of(c));
        drain();

        thr = '{52'd0, 52'hF_FFFF_FFFF_FFFF, 52'd1 << 20, 52'd1 << 45};
        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(thr[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 58; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 58; end
                default: begin send_idle_pct = 7; stall_pct = 7; end
            endcase
            if (ph == 2) begin
                // directed ties on threshold with the 4096 square area
                write_threshold(52'd16777216);
                c = '{0, 0, 0, 4096, 0, 0, 4096, 4096, 0, 0, 4096, 0};
                send_quad(quad_of(c));
                drain();
                write_threshold(52'd16777215);
                send_quad(quad_of(c));
                drain();
                write_threshold(thr[ph]);
            end
            random_phase(170);
            drain(); // sender waits until all areas are back
            random_phase(165);
            drain();
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
